[src/cea_pkg.sv]
`default_nettype none

package cea_pkg;

  localparam int unsigned SpkW       = 17;
  localparam int unsigned CntW       = 4;
  localparam int unsigned AllocW     = 8;
  localparam int unsigned CodeW      = 6;
  localparam int unsigned LayoutCnt  = 50;
  localparam int unsigned GroupSize  = 8;
  localparam int unsigned NumGroups  = (LayoutCnt + GroupSize - 1) / GroupSize;
  localparam logic [CntW-1:0]  MinMultiCh = 4'd2;
  localparam logic [CodeW-1:0] CodeNone   = 6'h00;
  localparam logic [CodeW-1:0] CodeMax    = 6'h31;

  typedef logic [SpkW-1:0] spk_mask_t;
  typedef logic [CodeW-1:0] ca_code_t;
  typedef logic [LayoutCnt-1:0] hit_vec_t;

  typedef struct packed {
    logic     valid;
    hit_vec_t hits;
  } match_t;

  // speaker positions
  localparam spk_mask_t SpFL  = 17'h00001;
  localparam spk_mask_t SpFC  = 17'h00002;
  localparam spk_mask_t SpFR  = 17'h00004;
  localparam spk_mask_t SpFLC = 17'h00008;
  localparam spk_mask_t SpFRC = 17'h00010;
  localparam spk_mask_t SpRL  = 17'h00020;
  localparam spk_mask_t SpRC  = 17'h00040;
  localparam spk_mask_t SpRR  = 17'h00080;
  localparam spk_mask_t SpRLC = 17'h00100;
  localparam spk_mask_t SpRRC = 17'h00200;
  localparam spk_mask_t SpLFE = 17'h00400;
  localparam spk_mask_t SpFLW = 17'h00800;
  localparam spk_mask_t SpFRW = 17'h01000;
  localparam spk_mask_t SpFLH = 17'h02000;
  localparam spk_mask_t SpFCH = 17'h04000;
  localparam spk_mask_t SpFRH = 17'h08000;
  localparam spk_mask_t SpTC  = 17'h10000;

  localparam spk_mask_t PF  = SpFL | SpFR;
  localparam spk_mask_t PR  = SpRL | SpRR;
  localparam spk_mask_t PFC = SpFLC | SpFRC;
  localparam spk_mask_t PRC = SpRLC | SpRRC;
  localparam spk_mask_t PW  = SpFLW | SpFRW;
  localparam spk_mask_t PH  = SpFLH | SpFRH;

  localparam ca_code_t LAYOUT_CODE [LayoutCnt] = '{
    6'h00, 6'h01, 6'h02, 6'h08, 6'h09, 6'h0a, 6'h0b, 6'h0f, 6'h13, 6'h03,
    6'h04, 6'h05, 6'h06, 6'h07, 6'h0c, 6'h0d, 6'h0e, 6'h10, 6'h11, 6'h12,
    6'h14, 6'h15, 6'h16, 6'h17, 6'h18, 6'h19, 6'h1a, 6'h1b, 6'h1c, 6'h1d,
    6'h1e, 6'h1f, 6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27,
    6'h28, 6'h29, 6'h2a, 6'h2b, 6'h2c, 6'h2d, 6'h2e, 6'h2f, 6'h30, 6'h31
  };

  localparam spk_mask_t LAYOUT_MASK [LayoutCnt] = '{
    PF,
    PF | SpLFE,
    PF | SpFC,
    PF | PR,
    PF | PR | SpLFE,
    PF | SpFC | PR,
    PF | SpFC | PR | SpLFE,
    PF | SpFC | PR | SpRC | SpLFE,
    PF | SpFC | PR | PRC | SpLFE,
    PF | SpFC | SpLFE,
    PF | SpRC,
    PF | SpRC | SpLFE,
    PF | SpFC | SpRC,
    PF | SpFC | SpRC | SpLFE,
    PF | PR | SpRC,
    PF | PR | SpRC | SpLFE,
    PF | SpFC | PR | SpRC,
    PF | PR | PRC,
    PF | PR | PRC | SpLFE,
    PF | SpFC | PR | PRC,
    PF | PFC,
    PF | PFC | SpLFE,
    PF | SpFC | PFC,
    PF | SpFC | PFC | SpLFE,
    PF | SpRC | PFC,
    PF | SpRC | PFC | SpLFE,
    PF | SpFC | SpRC | PFC,
    PF | SpFC | SpRC | PFC | SpLFE,
    PF | PR | PFC,
    PF | PR | PFC | SpLFE,
    PF | SpFC | PR | PFC,
    PF | SpFC | PR | PFC | SpLFE,
    PF | SpFC | PR | SpFCH,
    PF | SpFC | PR | SpFCH | SpLFE,
    PF | SpFC | PR | SpTC,
    PF | SpFC | PR | SpTC | SpLFE,
    PF | PR | PH,
    PF | PR | PH | SpLFE,
    PF | PR | PW,
    PF | PR | PW | SpLFE,
    PF | SpFC | PR | SpRC | SpTC,
    PF | SpFC | PR | SpRC | SpTC | SpLFE,
    PF | SpFC | PR | SpRC | SpFCH,
    PF | SpFC | PR | SpRC | SpFCH | SpLFE,
    PF | SpFC | PR | SpFCH | SpTC,
    PF | SpFC | PR | SpFCH | SpTC | SpLFE,
    PF | SpFC | PR | PH,
    PF | SpFC | PR | PH | SpLFE,
    PF | SpFC | PR | PW,
    PF | SpFC | PR | PW | SpLFE
  };

  function automatic spk_mask_t expand_alloc(logic [AllocW-1:0] alloc);
    spk_mask_t m;
    m = '0;
    if (alloc[0]) m = m | PF;
    if (alloc[1]) m = m | SpLFE;
    if (alloc[2]) m = m | SpFC;
    if (alloc[3]) m = m | PR;
    if (alloc[4]) m = m | SpRC;
    if (alloc[5]) m = m | PFC;
    if (alloc[6]) m = m | PRC;
    if (alloc[7]) m = m | PW;
    return m;
  endfunction

endpackage

`default_nettype wire

[src/cea_channel_allocation_select.sv]
// Audio infoframe channel allocation select. Give a channel count, the
// sink's speaker allocation byte and its valid flag with start_i; the
// channel allocation code comes out on ca_code_o with done_o at the end
// of a four-stage pipeline (input register, parallel layout compare,
// per-group first-match select, final group select), so a new
// transaction is taken every cycle and busy_o stays low. The receiver
// cannot stall: each code is shown for one cycle only and must be captured
// then. An invalid allocation or a count of two or fewer yields code 0.
`default_nettype none

module cea_channel_allocation_select (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [cea_pkg::CntW-1:0]   channel_count_i,
  input  wire logic [cea_pkg::AllocW-1:0] speaker_alloc_i,
  input  wire logic                        alloc_valid_i,
  output logic                             done_o,
  output logic [cea_pkg::CodeW-1:0]       ca_code_o
);

  logic                        in_valid_q;
  logic                        enable_q;
  logic [cea_pkg::CntW-1:0]   count_q;
  logic [cea_pkg::AllocW-1:0] alloc_q;
  cea_pkg::match_t             match;
  logic                        accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    enable_q <= alloc_valid_i && (channel_count_i > cea_pkg::MinMultiCh);
    count_q  <= channel_count_i;
    alloc_q  <= speaker_alloc_i;
  end

  cea_match u_match (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_q),
    .enable_i       (enable_q),
    .channel_count_i(count_q),
    .speaker_alloc_i(alloc_q),
    .match_o        (match)
  );

  cea_prienc u_prienc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .match_i(match),
    .valid_o(done_o),
    .code_o (ca_code_o)
  );

endmodule

`default_nettype wire

[src/cea_match.sv]
`default_nettype none

module cea_match (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic                        enable_i,
  input  wire logic [cea_pkg::CntW-1:0]   channel_count_i,
  input  wire logic [cea_pkg::AllocW-1:0] speaker_alloc_i,
  output cea_pkg::match_t                  match_o
);

  logic              valid_q;
  cea_pkg::hit_vec_t hits_d, hits_q;
  cea_pkg::spk_mask_t sink;

  // compare against every layout in parallel
  always_comb begin
    sink = cea_pkg::expand_alloc(speaker_alloc_i);
    for (int i = 0; i < cea_pkg::LayoutCnt; i++) begin
      hits_d[i] = enable_i
          && (channel_count_i == cea_pkg::CntW'($countones(cea_pkg::LAYOUT_MASK[i])))
          && ((sink & cea_pkg::LAYOUT_MASK[i]) == cea_pkg::LAYOUT_MASK[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hits_q <= hits_d;
  end

  assign match_o.valid = valid_q;
  assign match_o.hits  = hits_q;

endmodule

`default_nettype wire

[src/cea_prienc.sv]
`default_nettype none

module cea_prienc (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cea_pkg::match_t  match_i,
  output logic                  valid_o,
  output cea_pkg::ca_code_t     code_o
);

  localparam int unsigned NG = cea_pkg::NumGroups;
  localparam int unsigned GS = cea_pkg::GroupSize;

  logic                  grp_valid_q;
  logic [NG-1:0]         grp_hit_d, grp_hit_q;
  cea_pkg::ca_code_t     grp_code_d [NG];
  cea_pkg::ca_code_t     grp_code_q [NG];
  logic                  valid_q;
  cea_pkg::ca_code_t     code_d, code_q;

  // first match inside each group of layouts
  for (genvar g = 0; g < NG; g++) begin : g_grp
    logic [GS-1:0]     hit;
    cea_pkg::ca_code_t code [GS];
    cea_pkg::ca_code_t first;
    for (genvar j = 0; j < GS; j++) begin : g_ent
      if (g * GS + j < cea_pkg::LayoutCnt) begin : g_used
        assign hit[j]  = match_i.hits[g * GS + j];
        assign code[j] = cea_pkg::LAYOUT_CODE[g * GS + j];
      end else begin : g_pad
        assign hit[j]  = 1'b0;
        assign code[j] = cea_pkg::CodeNone;
      end
    end
    always_comb begin
      first = cea_pkg::CodeNone;
      for (int k = GS - 1; k >= 0; k--) begin
        if (hit[k]) first = code[k];
      end
    end
    assign grp_hit_d[g]  = |hit;
    assign grp_code_d[g] = first;
  end

  // first group with a match
  always_comb begin
    code_d = cea_pkg::CodeNone;
    for (int k = NG - 1; k >= 0; k--) begin
      if (grp_hit_q[k]) code_d = grp_code_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      grp_valid_q <= match_i.valid;
      valid_q     <= grp_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_hit_q  <= grp_hit_d;
    grp_code_q <= grp_code_d;
    code_q     <= code_d;
  end

  assign valid_o = valid_q;
  assign code_o  = code_q;

endmodule

`default_nettype wire

[src/cea_checker.sv]
`default_nettype none

module cea_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start_i,
  input wire logic                        busy_o,
  input wire logic [cea_pkg::CntW-1:0]   channel_count_i,
  input wire logic                        alloc_valid_i,
  input wire logic                        done_o,
  input wire logic [cea_pkg::CodeW-1:0]  ca_code_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o)
    else $error("transaction without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##4 !done_o)
    else $error("result without transaction");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (ca_code_o <= cea_pkg::CodeMax))
    else $error("code out of range");

  a_zero_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (!alloc_valid_i || channel_count_i <= cea_pkg::MinMultiCh))
      |-> ##4 (ca_code_o == cea_pkg::CodeNone))
    else $error("nonzero code for stereo or invalid allocation");

endmodule

bind cea_channel_allocation_select cea_checker u_cea_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .channel_count_i(channel_count_i),
  .alloc_valid_i  (alloc_valid_i),
  .done_o         (done_o),
  .ca_code_o      (ca_code_o)
);

`default_nettype wire
